[src/hkc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Half-width katakana converter package
// Shared types, code constants and the kana lookup tables.
// ----------------------------------------------------------------------------
package hkc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] HIRA_FIRST  = 16'h3041;
  localparam logic [15:0] HIRA_LAST   = 16'h3096;
  localparam logic [15:0] HIRA_SHIFT  = 16'h0060;
  localparam logic [15:0] KATA_FIRST  = 16'h30A1;
  localparam logic [15:0] KATA_LAST   = 16'h30F6;
  localparam logic [15:0] MARK_VOICED = 16'hFF9E;
  localparam logic [15:0] MARK_SEMI   = 16'hFF9F;
  localparam logic [7:0]  HALF_HIGH   = 8'hFF;

  localparam int unsigned KANA_COUNT = 86;
  localparam int unsigned KANA_IDX_W = $clog2(KANA_COUNT);

  typedef enum logic [1:0] {
    MARK_NONE     = 2'd0,
    MARK_DAKU     = 2'd1,
    MARK_HANDAKU  = 2'd2
  } mark_e;

  // one classified word waiting for the back end
  typedef struct packed {
    logic [15:0] unit;
    mark_e       mark;
    logic        eot;
  } q_word_t;

  // low byte of the half-width base; high byte is always 0xFF
  localparam logic [7:0] KANA_BASE [KANA_COUNT] = '{
    8'h67, 8'h71, 8'h68, 8'h72, 8'h69, 8'h73, 8'h6A, 8'h74, 8'h6B, 8'h75,
    8'h76, 8'h76, 8'h77, 8'h77, 8'h78, 8'h78, 8'h79, 8'h79, 8'h7A, 8'h7A,
    8'h7B, 8'h7B, 8'h7C, 8'h7C, 8'h7D, 8'h7D, 8'h7E, 8'h7E, 8'h7F, 8'h7F,
    8'h80, 8'h80, 8'h81, 8'h81, 8'h6F, 8'h82, 8'h82, 8'h83, 8'h83, 8'h84, 8'h84,
    8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h8A, 8'h8A, 8'h8B, 8'h8B, 8'h8B, 8'h8C, 8'h8C, 8'h8C,
    8'h8D, 8'h8D, 8'h8D, 8'h8E, 8'h8E, 8'h8E,
    8'h8F, 8'h90, 8'h91, 8'h92, 8'h93,
    8'h6C, 8'h94, 8'h6D, 8'h95, 8'h6E, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B,
    8'h9C, 8'h9C, 8'h72, 8'h74, 8'h66,
    8'h9D, 8'h73, 8'h76, 8'h79
  };

  localparam mark_e KANA_MARK [KANA_COUNT] = '{
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE,
    MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU,
    MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE,
    MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU,
    MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE,
    MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU, MARK_NONE, MARK_DAKU,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_DAKU, MARK_HANDAKU, MARK_NONE, MARK_DAKU, MARK_HANDAKU,
    MARK_NONE, MARK_DAKU, MARK_HANDAKU,
    MARK_NONE, MARK_DAKU, MARK_HANDAKU, MARK_NONE, MARK_DAKU, MARK_HANDAKU,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE,
    MARK_NONE, MARK_DAKU, MARK_NONE, MARK_NONE
  };

  // half-width form of a symbol, or the unit itself when it is not one
  function automatic logic [15:0] symbol_form(input logic [15:0] u);
    logic [15:0] r;
    case (u)
      16'h30FC: r = 16'hFF70;
      16'h30FB: r = 16'hFF65;
      16'h300C: r = 16'hFF62;
      16'h300D: r = 16'hFF63;
      16'h3001: r = 16'hFF64;
      16'h3002: r = 16'hFF61;
      16'h309B: r = MARK_VOICED;
      16'h309C: r = MARK_SEMI;
      default:  r = u;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/hkc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts input words while the queue has room and classifies them into a
// base unit plus an optional sound mark.
// ----------------------------------------------------------------------------
module hkc_front (
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [15:0]     code_unit_i,
  input  wire logic            end_of_text_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output hkc_pkg::q_word_t     word_o
);
  import hkc_pkg::*;

  logic [15:0]           unit_k;
  logic                  is_kata;
  logic [KANA_IDX_W-1:0] idx;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    // hiragana moves up into the katakana block first
    if (code_unit_i >= HIRA_FIRST && code_unit_i <= HIRA_LAST) begin
      unit_k = code_unit_i + HIRA_SHIFT;
    end else begin
      unit_k = code_unit_i;
    end
    is_kata = (unit_k >= KATA_FIRST) && (unit_k <= KATA_LAST);
    idx     = KANA_IDX_W'(unit_k - KATA_FIRST);

    word_o.eot = end_of_text_i;
    if (is_kata) begin
      word_o.unit = {HALF_HIGH, KANA_BASE[idx]};
      word_o.mark = KANA_MARK[idx];
    end else begin
      word_o.unit = symbol_form(unit_k);
      word_o.mark = MARK_NONE;
    end
  end

endmodule
`default_nettype wire

[src/hkc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word queue
// Small FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module hkc_queue #(
  parameter int unsigned Depth = hkc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire hkc_pkg::q_word_t wdata_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output hkc_pkg::q_word_t      rdata_o
);
  import hkc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_word_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count lost a pop");

endmodule
`default_nettype wire

[src/hkc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Drains the queue into the output register; a voiced word goes out as the
// base followed by its sound mark.
// ----------------------------------------------------------------------------
module hkc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire hkc_pkg::q_word_t q_word_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [15:0]           out_unit_o,
  output logic                  last_of_run_o,
  output logic                  text_done_o
);
  import hkc_pkg::*;

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  logic [15:0] unit_q, unit_d;
  logic        last_q, last_d;
  logic        done_q, done_d;
  logic [15:0] pend_unit_q, pend_unit_d;
  logic        pend_eot_q, pend_eot_d;
  logic [15:0] mark_unit;
  logic        load;

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && q_valid_i;

  always_comb begin
    case (q_word_i.mark)
      MARK_DAKU:    mark_unit = MARK_VOICED;
      MARK_HANDAKU: mark_unit = MARK_SEMI;
      default:      mark_unit = MARK_VOICED;
    endcase
  end

  always_comb begin
    valid_d     = valid_q;
    pend_d      = pend_q;
    unit_d      = unit_q;
    last_d      = last_q;
    done_d      = done_q;
    pend_unit_d = pend_unit_q;
    pend_eot_d  = pend_eot_q;
    if (load) begin
      if (pend_q) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        unit_d  = pend_unit_q;
        last_d  = 1'b1;
        done_d  = pend_eot_q;
      end else if (q_valid_i) begin
        valid_d = 1'b1;
        unit_d  = q_word_i.unit;
        if (q_word_i.mark == MARK_NONE) begin
          last_d = 1'b1;
          done_d = q_word_i.eot;
        end else begin
          // base goes now; mark word waits in pend_unit_q until the output register is free
          last_d      = 1'b0;
          done_d      = 1'b0;
          pend_d      = 1'b1;
          pend_unit_d = mark_unit;
          pend_eot_d  = q_word_i.eot;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q      <= unit_d;
    last_q      <= last_d;
    done_q      <= done_d;
    pend_unit_q <= pend_unit_d;
    pend_eot_q  <= pend_eot_d;
  end

  assign out_valid_o   = valid_q;
  assign out_unit_o    = unit_q;
  assign last_of_run_o = last_q;
  assign text_done_o   = done_q;

  a_pend_has_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (valid_q && !last_q))
    else $error("pending mark without its base word on the output");

  a_first_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |-> pend_q)
    else $error("non-final word with nothing to follow");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && done_q) |-> last_q)
    else $error("text_done on a non-final word");

  a_no_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_o)
    else $error("queue popped while a mark word is pending");

endmodule
`default_nettype wire

[src/halfwidth_katakana_converter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Half-width katakana converter
// Converts a stream of UTF-16 code units, one per word, to half-width
// katakana.
//
// Input channel: in_valid_i / in_stall_o with code_unit_i and end_of_text_i.
// Output channel: out_valid_o / out_stall_i with out_unit_o, last_of_run_o
// and text_done_o. A word moves at an edge with valid high and stall low.
// Each input word gives one output word, or two for voiced and semi-voiced
// kana (base, then the sound mark); last_of_run_o marks the final one and
// text_done_o carries end_of_text_i onto it.
// Path: an input word is written into the word queue, then loaded into the
// output register. Throughput: one input word per cycle while in_stall_o
// is low; a voiced kana holds the output register for base and mark, the
// word queue (QueueDepth entries) takes the extra words until it is full.
// Reset empties the queue and the output register; no words are pending.
// While out_stall_i is high the output word holds and input keeps flowing
// until the queue fills.
// ----------------------------------------------------------------------------
module halfwidth_katakana_converter_top #(
  parameter int unsigned QueueDepth = hkc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      out_unit_o,
  output logic             last_of_run_o,
  output logic             text_done_o
);
  import hkc_pkg::*;

  q_word_t in_word;
  q_word_t head_word;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;

  hkc_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_unit_i   (code_unit_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .word_o        (in_word)
  );

  hkc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_word),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (head_word)
  );

  hkc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_word_i      (head_word),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_unit_o    (out_unit_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule
`default_nettype wire
